// File: src/rgbapk_pkg.sv
package rgbapk_pkg;

    localparam int NUM_CH    = 4;
    localparam int FRAC_BITS = 16;
    localparam int CH_W      = 17;
    localparam int COL_W     = 2 * CH_W;
    localparam int SCALE_W   = 16;
    localparam int CODE_W    = 16;
    localparam int WORD_W    = 64;
    localparam int BITS_W    = 5;
    localparam int SHIFT_W   = 6;
    localparam int FMT_W     = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 4;

    // Lane order inside the pipeline.
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_ALPHA   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PREMULTIPLY  = 2'd2;

    // Layout codes that the logic treats specially.
    localparam logic [FMT_W-1:0] FMT_A8B8G8R8     = 4'd1;
    localparam logic [FMT_W-1:0] FMT_A16B16G16R16 = 4'd6;
    localparam logic [FMT_W-1:0] FMT_R5G6B5       = 4'd7;

    typedef logic [COL_W-1:0]   t_col;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [BITS_W-1:0]  t_bits;
    typedef logic [SHIFT_W-1:0] t_shift;

    typedef struct packed {
        logic             valid;
        logic [FMT_W-1:0] fmt;
        logic             half_alpha;
        logic             premul;
    } t_ctl;

    // Field widths per layout, lanes red, green, blue, alpha.
    localparam logic [BITS_W-1:0] LAY_BITS [16][NUM_CH] = '{
        '{5'd8,  5'd8,  5'd8,  5'd8},
        '{5'd8,  5'd8,  5'd8,  5'd8},
        '{5'd8,  5'd8,  5'd8,  5'd8},
        '{5'd8,  5'd8,  5'd8,  5'd8},
        '{5'd10, 5'd10, 5'd10, 5'd2},
        '{5'd10, 5'd10, 5'd10, 5'd2},
        '{5'd16, 5'd16, 5'd16, 5'd16},
        '{5'd5,  5'd6,  5'd5,  5'd0},
        '{5'd6,  5'd5,  5'd5,  5'd0},
        '{5'd5,  5'd6,  5'd5,  5'd0},
        '{5'd5,  5'd5,  5'd5,  5'd1},
        '{5'd5,  5'd5,  5'd5,  5'd1},
        '{5'd5,  5'd5,  5'd5,  5'd1},
        '{5'd4,  5'd4,  5'd4,  5'd4},
        '{5'd4,  5'd4,  5'd4,  5'd4},
        '{5'd4,  5'd4,  5'd4,  5'd4}
    };

    localparam logic [SHIFT_W-1:0] LAY_SHIFT [16][NUM_CH] = '{
        '{6'd16, 6'd8,  6'd0,  6'd24},
        '{6'd0,  6'd8,  6'd16, 6'd24},
        '{6'd8,  6'd16, 6'd24, 6'd0},
        '{6'd24, 6'd16, 6'd8,  6'd0},
        '{6'd20, 6'd10, 6'd0,  6'd30},
        '{6'd0,  6'd10, 6'd20, 6'd30},
        '{6'd0,  6'd16, 6'd32, 6'd48},
        '{6'd11, 6'd5,  6'd0,  6'd0},
        '{6'd10, 6'd5,  6'd0,  6'd0},
        '{6'd0,  6'd5,  6'd11, 6'd0},
        '{6'd10, 6'd5,  6'd0,  6'd15},
        '{6'd11, 6'd6,  6'd1,  6'd0},
        '{6'd0,  6'd5,  6'd10, 6'd15},
        '{6'd8,  6'd4,  6'd0,  6'd12},
        '{6'd0,  6'd4,  6'd8,  6'd12},
        '{6'd12, 6'd8,  6'd4,  6'd0}
    };

    function automatic t_bits lay_bits(input logic [FMT_W-1:0] fmt, input int lane);
        return LAY_BITS[fmt][lane];
    endfunction

    function automatic t_shift lay_shift(input logic [FMT_W-1:0] fmt, input int lane);
        return LAY_SHIFT[fmt][lane];
    endfunction

endpackage

// File: src/rgbapk_premul.sv
module rgbapk_premul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rgbapk_pkg::t_ctl                       i_ctl,
    input  logic [rgbapk_pkg::NUM_CH-1:0][rgbapk_pkg::CH_W-1:0] i_chan,
    output rgbapk_pkg::t_ctl                       o_ctl,
    output rgbapk_pkg::t_col [rgbapk_pkg::NUM_CH-1:0] o_col
);

    rgbapk_pkg::t_col [rgbapk_pkg::NUM_CH-1:0] n_col;
    rgbapk_pkg::t_col [rgbapk_pkg::NUM_CH-1:0] r_col;
    logic                                      r_valid;
    rgbapk_pkg::t_ctl                          r_ctl;

    // Every lane leaves with 2 * FRAC_BITS fraction bits, so the quantizer
    // treats alpha the same way as the colour lanes.
    always_comb begin
        for (int i = 0; i < rgbapk_pkg::NUM_CH - 1; i++) begin
            if (i_ctl.premul) begin
                n_col[i] = rgbapk_pkg::COL_W'(i_chan[i])
                         * rgbapk_pkg::COL_W'(i_chan[rgbapk_pkg::LANE_ALPHA]);
            end else begin
                n_col[i] = rgbapk_pkg::COL_W'(i_chan[i]) << rgbapk_pkg::FRAC_BITS;
            end
        end
        n_col[rgbapk_pkg::LANE_ALPHA] =
            rgbapk_pkg::COL_W'(i_chan[rgbapk_pkg::LANE_ALPHA]) << rgbapk_pkg::FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_ctl <= i_ctl;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_comb begin
        o_ctl       = r_ctl;
        o_ctl.valid = r_valid;
    end

    assign o_col = r_col;

endmodule

// File: src/rgbapk_quant.sv
module rgbapk_quant (
    input  logic               i_clk,
    input  rgbapk_pkg::t_col   i_col,
    input  rgbapk_pkg::t_bits  i_bits,
    input  logic               i_half_scale,
    output rgbapk_pkg::t_code  o_code
);

    localparam int PROD_W = rgbapk_pkg::COL_W + rgbapk_pkg::SCALE_W;

    logic [rgbapk_pkg::SCALE_W:0]   w_scale_ext;
    logic [rgbapk_pkg::SCALE_W-1:0] w_scale;
    logic [rgbapk_pkg::CODE_W-1:0]  w_mask;
    logic [PROD_W-1:0]              w_prod;
    rgbapk_pkg::t_code              n_code;
    rgbapk_pkg::t_code              r_code;

    always_comb begin
        w_scale_ext = ((rgbapk_pkg::SCALE_W + 1)'(1) << i_bits) - (rgbapk_pkg::SCALE_W + 1)'(1);
        w_mask      = w_scale_ext[rgbapk_pkg::SCALE_W-1:0];
        // The half alpha scale maps 1.0 to 128; the mask still follows the field width.
        w_scale     = i_half_scale ? rgbapk_pkg::SCALE_W'(128) : w_mask;
        w_prod      = PROD_W'(i_col) * PROD_W'(w_scale);
        n_code      = w_prod[2*rgbapk_pkg::FRAC_BITS +: rgbapk_pkg::CODE_W] & w_mask;
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

// File: src/rgba_pixel_format_packer_top.sv
// Channel    Direction  Signals                                  Transaction when
// cfg        in         i_cfg_wr_en, i_cfg_addr, i_cfg_wdata     i_cfg_wr_en high at a clock edge
// pixel      in         i_start, o_busy, i_red .. i_alpha        i_start high and o_busy low
// packed     out        o_valid, o_packed_word                   o_valid high for one cycle
//
// One pixel is taken every clock cycle; o_busy is always low.
// The pipeline registers are the input register, the premultiply multiplier,
// the quantize multiplier per lane, and the field placement and merge register.
// Reset clears the valid bits of every stage and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module rgba_pixel_format_packer_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [rgbapk_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [rgbapk_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic [rgbapk_pkg::CH_W-1:0]            i_red,
    input  logic [rgbapk_pkg::CH_W-1:0]            i_green,
    input  logic [rgbapk_pkg::CH_W-1:0]            i_blue,
    input  logic [rgbapk_pkg::CH_W-1:0]            i_alpha,
    output logic                                   o_valid,
    output logic [rgbapk_pkg::WORD_W-1:0]          o_packed_word
);

    logic [rgbapk_pkg::FMT_W-1:0] r_pixel_format;
    logic                         r_half_alpha;
    logic                         r_premul;

    rgbapk_pkg::t_ctl                                       r_s1_ctl;
    logic [rgbapk_pkg::NUM_CH-1:0][rgbapk_pkg::CH_W-1:0]    r_s1_chan;
    rgbapk_pkg::t_ctl                                       w_s2_ctl;
    rgbapk_pkg::t_col [rgbapk_pkg::NUM_CH-1:0]              w_s2_col;
    rgbapk_pkg::t_ctl                                       r_s3_ctl;
    rgbapk_pkg::t_code [rgbapk_pkg::NUM_CH-1:0]             w_s3_code;
    rgbapk_pkg::t_bits [rgbapk_pkg::NUM_CH-1:0]             w_s2_bits;
    logic [rgbapk_pkg::NUM_CH-1:0]                          w_s2_half;
    logic                                                   r_out_valid;
    logic [rgbapk_pkg::FMT_W-1:0]                           r_out_fmt;
    logic [rgbapk_pkg::WORD_W-1:0]                          r_word;
    logic [rgbapk_pkg::WORD_W-1:0]                          n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= '0;
            r_half_alpha   <= 1'b0;
            r_premul       <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                rgbapk_pkg::REG_PIXEL_FORMAT: r_pixel_format <= i_cfg_wdata;
                rgbapk_pkg::REG_HALF_ALPHA:   r_half_alpha   <= i_cfg_wdata[0];
                rgbapk_pkg::REG_PREMULTIPLY:  r_premul       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // Stage 1: input register with a snapshot of the configuration.
    always_ff @(posedge i_clk) begin
        r_s1_chan[rgbapk_pkg::LANE_RED]   <= i_red;
        r_s1_chan[rgbapk_pkg::LANE_GREEN] <= i_green;
        r_s1_chan[rgbapk_pkg::LANE_BLUE]  <= i_blue;
        r_s1_chan[rgbapk_pkg::LANE_ALPHA] <= i_alpha;
        r_s1_ctl.fmt        <= r_pixel_format;
        r_s1_ctl.half_alpha <= r_half_alpha;
        r_s1_ctl.premul     <= r_premul;
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
        end else begin
            r_s1_ctl.valid <= i_start && !o_busy;
        end
    end

    // Stage 2: premultiply.
    rgbapk_premul u_premul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s1_ctl),
        .i_chan  (r_s1_chan),
        .o_ctl   (w_s2_ctl),
        .o_col   (w_s2_col)
    );

    // Stage 3: quantize each lane.
    for (genvar g = 0; g < rgbapk_pkg::NUM_CH; g++) begin : g_lane
        assign w_s2_bits[g] = rgbapk_pkg::lay_bits(w_s2_ctl.fmt, g);
        if (g == rgbapk_pkg::LANE_ALPHA) begin : g_alpha
            assign w_s2_half[g] = w_s2_ctl.half_alpha
                               && (w_s2_ctl.fmt == rgbapk_pkg::FMT_A8B8G8R8);
        end else begin : g_color
            assign w_s2_half[g] = 1'b0;
        end
        rgbapk_quant u_quant (
            .i_clk        (i_clk),
            .i_col        (w_s2_col[g]),
            .i_bits       (w_s2_bits[g]),
            .i_half_scale (w_s2_half[g]),
            .o_code       (w_s3_code[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_s3_ctl.fmt        <= w_s2_ctl.fmt;
        r_s3_ctl.half_alpha <= w_s2_ctl.half_alpha;
        r_s3_ctl.premul     <= w_s2_ctl.premul;
        if (!i_rst_n) begin
            r_s3_ctl.valid <= 1'b0;
        end else begin
            r_s3_ctl.valid <= w_s2_ctl.valid;
        end
    end

    // Stage 4: move each code into its field and merge.
    always_comb begin
        n_word = '0;
        for (int i = 0; i < rgbapk_pkg::NUM_CH; i++) begin
            n_word = n_word | (rgbapk_pkg::WORD_W'(w_s3_code[i])
                               << rgbapk_pkg::lay_shift(r_s3_ctl.fmt, i));
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_out_fmt <= r_s3_ctl.fmt;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s3_ctl.valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_word = r_word;

    a_valid_follows_stage3 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_ctl.valid |=> o_valid)
        else $error("quantized pixel did not reach the output");

    a_no_phantom_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_ctl.valid && !w_s2_ctl.valid ##2 1'b1 |-> !o_valid)
        else $error("result strobe without a pixel in flight");

    a_narrow_upper_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_out_fmt >= rgbapk_pkg::FMT_R5G6B5) |-> (o_packed_word[63:16] == '0))
        else $error("16-bit layout drives bits above bit 15");

    a_word32_upper_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_out_fmt < rgbapk_pkg::FMT_A16B16G16R16)
        |-> (o_packed_word[63:32] == '0))
        else $error("32-bit layout drives bits above bit 31");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef enum logic [3:0] {
        PF_ARGB8888, PF_ABGR8888, PF_BGRA8888, PF_RGBA8888,
        PF_A2RGB10,  PF_A2BGR10,  PF_ABGR16,   PF_RGB565,
        PF_RGB655,   PF_BGR565,   PF_ARGB1555, PF_RGBA5551,
        PF_ABGR1555, PF_ARGB4444, PF_ABGR4444, PF_RGBA4444
    } pix_fmt_e;

    localparam int LANE_R = 0;
    localparam int LANE_G = 1;
    localparam int LANE_B = 2;
    localparam int LANE_A = 3;
    localparam int CYCLE_LIMIT = 60000;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 95;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_wr_en = 1'b0;
    logic [rgbapk_pkg::CFG_ADDR_W-1:0]     i_cfg_addr = '0;
    logic [rgbapk_pkg::CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                                  i_start = 1'b0;
    logic                                  o_busy;
    logic [rgbapk_pkg::CH_W-1:0]           i_red = '0;
    logic [rgbapk_pkg::CH_W-1:0]           i_green = '0;
    logic [rgbapk_pkg::CH_W-1:0]           i_blue = '0;
    logic [rgbapk_pkg::CH_W-1:0]           i_alpha = '0;
    logic                                  o_valid;
    logic [rgbapk_pkg::WORD_W-1:0]         o_packed_word;

    // Mirror of the configuration registers, at their reset values.
    pix_fmt_e    fmt_sel = PF_ARGB8888;
    logic        half_alpha_sel = 1'b0;
    logic        premul_sel = 1'b1;

    logic [63:0] expected_words[$];
    logic [63:0] oldest_word;
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b0;

    rgba_pixel_format_packer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_alpha       (i_alpha),
        .o_valid       (o_valid),
        .o_packed_word (o_packed_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Field width and bit position of one lane in a layout; width 0 means absent.
    function automatic void field_layout(input pix_fmt_e f, input int lane,
                                         output int unsigned width,
                                         output int unsigned pos);
        int unsigned w[4];
        int unsigned p[4];
        case (f)
            PF_ARGB8888: begin w = '{8, 8, 8, 8};     p = '{16, 8, 0, 24}; end
            PF_ABGR8888: begin w = '{8, 8, 8, 8};     p = '{0, 8, 16, 24}; end
            PF_BGRA8888: begin w = '{8, 8, 8, 8};     p = '{8, 16, 24, 0}; end
            PF_RGBA8888: begin w = '{8, 8, 8, 8};     p = '{24, 16, 8, 0}; end
            PF_A2RGB10:  begin w = '{10, 10, 10, 2};  p = '{20, 10, 0, 30}; end
            PF_A2BGR10:  begin w = '{10, 10, 10, 2};  p = '{0, 10, 20, 30}; end
            PF_ABGR16:   begin w = '{16, 16, 16, 16}; p = '{0, 16, 32, 48}; end
            PF_RGB565:   begin w = '{5, 6, 5, 0};     p = '{11, 5, 0, 0}; end
            PF_RGB655:   begin w = '{6, 5, 5, 0};     p = '{10, 5, 0, 0}; end
            PF_BGR565:   begin w = '{5, 6, 5, 0};     p = '{0, 5, 11, 0}; end
            PF_ARGB1555: begin w = '{5, 5, 5, 1};     p = '{10, 5, 0, 15}; end
            PF_RGBA5551: begin w = '{5, 5, 5, 1};     p = '{11, 6, 1, 0}; end
            PF_ABGR1555: begin w = '{5, 5, 5, 1};     p = '{0, 5, 10, 15}; end
            PF_ARGB4444: begin w = '{4, 4, 4, 4};     p = '{8, 4, 0, 12}; end
            PF_ABGR4444: begin w = '{4, 4, 4, 4};     p = '{0, 4, 8, 12}; end
            default: begin w = '{4, 4, 4, 4};         p = '{12, 8, 4, 0}; end
        endcase
        width = w[lane];
        pos = p[lane];
    endfunction

    // Truncates value * scale down by frac fraction bits, wraps to width bits, places it.
    function automatic logic [63:0] place_code(input logic [63:0] value, input int frac,
                                               input logic [63:0] scale,
                                               input int unsigned width,
                                               input int unsigned pos);
        logic [63:0] mask;
        mask = (64'd1 << width) - 64'd1;
        return (((value * scale) >> frac) & mask) << pos;
    endfunction

    function automatic logic [63:0] packed_pixel(input logic [16:0] r, input logic [16:0] g,
                                                 input logic [16:0] b, input logic [16:0] a,
                                                 input pix_fmt_e f, input logic half,
                                                 input logic premul);
        logic [16:0] colour[3];
        logic [63:0] level;
        logic [63:0] scale;
        logic [63:0] word;
        int unsigned width;
        int unsigned pos;
        colour[LANE_R] = r;
        colour[LANE_G] = g;
        colour[LANE_B] = b;
        word = '0;
        // Colour levels carry 32 fraction bits whether premultiplied or not.
        for (int lane = LANE_R; lane <= LANE_B; lane++) begin
            level = premul ? 64'(colour[lane]) * 64'(a) : 64'(colour[lane]) << 16;
            field_layout(f, lane, width, pos);
            if (width != 0)
                word |= place_code(level, 32, (64'd1 << width) - 64'd1, width, pos);
        end
        field_layout(f, LANE_A, width, pos);
        if (width != 0) begin
            scale = (f == PF_ABGR8888 && half) ? 64'd128 : (64'd1 << width) - 64'd1;
            word |= place_code(64'(a), 16, scale, width, pos);
        end
        return word;
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Results are checked before new pixels are queued, so the order is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                if (expected_words.size() == 0) begin
                    $error("packed_word: expected none pending, actual %h", o_packed_word);
                    error_count++;
                end else begin
                    oldest_word = expected_words.pop_front();
                    if (o_packed_word !== oldest_word) begin
                        $error("packed_word: expected %h, actual %h",
                               oldest_word, o_packed_word);
                        error_count++;
                    end
                end
            end
            if (i_start && !o_busy)
                expected_words.push_back(packed_pixel(i_red, i_green, i_blue, i_alpha,
                                                      fmt_sel, half_alpha_sel, premul_sel));
        end
    end

    task automatic send_pixel(input logic [16:0] r, input logic [16:0] g,
                              input logic [16:0] b, input logic [16:0] a);
        if (idle_on && $urandom_range(99) < 5) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        i_alpha <= a;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Stops sending and waits until every queued pixel has come back. The first
    // edge lets the checker queue the transaction accepted at the previous edge.
    task automatic finish_stream();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // Writes all three registers in back-to-back transactions; only bit 0 of the
    // one-bit registers is meaningful.
    task automatic program_regs(input logic [3:0] fmt_data, input logic [3:0] half_data,
                                input logic [3:0] premul_data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= rgbapk_pkg::REG_PIXEL_FORMAT;
        i_cfg_wdata <= fmt_data;
        @(posedge i_clk);
        fmt_sel = pix_fmt_e'(fmt_data);
        i_cfg_addr  <= rgbapk_pkg::REG_HALF_ALPHA;
        i_cfg_wdata <= half_data;
        @(posedge i_clk);
        half_alpha_sel = half_data[0];
        i_cfg_addr  <= rgbapk_pkg::REG_PREMULTIPLY;
        i_cfg_wdata <= premul_data;
        @(posedge i_clk);
        premul_sel = premul_data[0];
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [16:0] rand_channel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20) begin
            case ($urandom_range(5))
                0: return 17'd0;
                1: return 17'd1;
                2: return 17'd65535;
                3: return 17'd65536;
                4: return 17'h1FFFF;
                default: return 17'd32768;
            endcase
        end
        if (pick < 35)
            return 17'($urandom_range(131071, 65537));
        return 17'($urandom_range(65536));
    endfunction

    task automatic test_reset_defaults();
        send_pixel(17'd0, 17'd0, 17'd0, 17'd0);
        send_pixel(17'd65536, 17'd32768, 17'd1, 17'd65536);
        finish_stream();
    endtask

    task automatic test_each_layout();
        for (int f = 0; f < 16; f++) begin
            program_regs(4'(f), 4'd0, 4'd0);
            send_pixel(17'd65536, 17'd43690, 17'd21845, 17'd49152);
            finish_stream();
        end
    endtask

    // Levels above 1.0 wrap through the field mask instead of saturating.
    task automatic test_channel_wrap();
        program_regs(PF_ABGR16, 4'd0, 4'd0);
        send_pixel(17'h1FFFF, 17'd65537, 17'd0, 17'h1FFFF);
        finish_stream();
        program_regs(PF_ABGR16, 4'd0, 4'd1);
        send_pixel(17'h1FFFF, 17'd65537, 17'd65535, 17'h1FFFF);
        finish_stream();
    endtask

    task automatic test_alpha_cases();
        // Upper data bits of the one-bit registers must be ignored.
        program_regs(PF_ABGR8888, 4'b1111, 4'b1110);
        send_pixel(17'd65536, 17'd65536, 17'd65536, 17'd65536);
        send_pixel(17'd1, 17'd2, 17'd3, 17'h1FFFF);
        send_pixel(17'd0, 17'd0, 17'd0, 17'd65535);
        finish_stream();
        program_regs(PF_ARGB1555, 4'b0010, 4'b0000);
        send_pixel(17'd65535, 17'd0, 17'd65536, 17'd65535);
        send_pixel(17'd0, 17'd65536, 17'd0, 17'd65536);
        send_pixel(17'd65536, 17'd65536, 17'd65536, 17'h1FFFF);
        finish_stream();
        // Without an alpha field, alpha still matters through premultiplication.
        program_regs(PF_RGB565, 4'd0, 4'd1);
        send_pixel(17'd65536, 17'd65536, 17'd65536, 17'd0);
        send_pixel(17'd65536, 17'd65536, 17'd65536, 17'd32768);
        finish_stream();
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_regs(PF_ARGB8888, 4'd0, 4'd0);
                1: program_regs(PF_RGBA4444, 4'd1, 4'd1);
                2: program_regs(PF_ABGR8888, 4'd1, 4'd0);
                3: program_regs(PF_ABGR8888, 4'd1, 4'd1);
                default: program_regs(4'($urandom_range(15)), 4'($urandom_range(15)),
                                       4'($urandom_range(15)));
            endcase
            // One phase runs with no idle cycles at all.
            idle_on = (phase != 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
            finish_stream();
        end
        idle_on = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_each_layout();
        test_channel_wrap();
        test_alpha_cases();
        test_random_stream();
        finish_stream();
        repeat (8) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("packed_word: %0d expected transactions never arrived",
                   expected_words.size());
            error_count++;
        end
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
